@@ src/wcpid_pkg.sv @@
// ============================================================================
// wcpid_pkg
// Shared types and constants of the wall centering PID controller
// ============================================================================
`default_nettype none

package wcpid_pkg;

    localparam logic [9:0]  RIGHT_SECTOR_END  = 10'd180;
    localparam logic [9:0]  LEFT_SECTOR_START = 10'd360;
    localparam logic [10:0] SCAN_LENGTH       = 11'd720;
    localparam logic [9:0]  POSITION_MAX      = 10'd1023;
    localparam logic [15:0] SPEED_STEP        = 16'd13;

    localparam logic [2:0] REG_GAIN_P      = 3'd0;
    localparam logic [2:0] REG_GAIN_I      = 3'd1;
    localparam logic [2:0] REG_GAIN_D      = 3'd2;
    localparam logic [2:0] REG_PERIOD      = 3'd3;
    localparam logic [2:0] REG_INV_PERIOD  = 3'd4;
    localparam logic [2:0] REG_OUT_LIMIT   = 3'd5;
    localparam logic [2:0] REG_CEILING     = 3'd6;
    localparam logic [2:0] REG_TARGET      = 3'd7;

    typedef struct packed {
        logic signed [15:0] gain_proportional;
        logic signed [15:0] gain_integral;
        logic signed [15:0] gain_derivative;
        logic [15:0]        sample_period;
        logic [15:0]        inverse_sample_period;
        logic [14:0]        output_limit;
        logic [15:0]        range_ceiling;
        logic [15:0]        target_speed;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DERIV,
        ST_INCR,
        ST_PROP,
        ST_INTG,
        ST_DIFF,
        ST_SUM,
        ST_CLAMP,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DERIV,
        OP_INCR,
        OP_PROP,
        OP_INTG,
        OP_DIFF
    } op_t;

    typedef struct packed {
        logic sample_take;
        op_t  op;
        logic finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ src/wall_centering_pid_controller.sv @@
// ============================================================================
// wall_centering_pid_controller
// Laser scan sector minima feeding a clamped PID with anti-windup and a
// forward speed ramp
// ============================================================================
// Range samples stream in one per cycle. The sample with tlast closes the
// scan and starts the PID update, which runs five products through one
// shared 33x17 multiplier followed by rounding, clamping and a result
// register: s_tready stays low from that sample through ST_DERIV to ST_OUT,
// and ST_OUT holds while a previous result still waits on m_tready. One
// result item leaves per scan. Configuration writes are always ready.
`default_nettype none

module wall_centering_pid_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // range_sample
    input  wire logic        s_tlast,   // end_of_scan
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // steer_command, forward_speed
    output logic             m_tuser,   // clamped
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import wcpid_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    wcpid_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wcpid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wcpid_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .range_sample (s_tdata),
        .end_of_scan  (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

`default_nettype wire

@@ src/wcpid_cfg.sv @@
// ============================================================================
// wcpid_cfg
// Configuration register file, written through the index/data channel
// ============================================================================
`default_nettype none

module wcpid_cfg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [15:0]      cfg_data,
    output wcpid_pkg::cfg_t       cfg
);
    import wcpid_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_GAIN_P:     cfg_next.gain_proportional     = $signed(cfg_data);
                REG_GAIN_I:     cfg_next.gain_integral         = $signed(cfg_data);
                REG_GAIN_D:     cfg_next.gain_derivative       = $signed(cfg_data);
                REG_PERIOD:     cfg_next.sample_period         = cfg_data;
                REG_INV_PERIOD: cfg_next.inverse_sample_period = cfg_data;
                REG_OUT_LIMIT:  cfg_next.output_limit          = cfg_data[14:0];
                REG_CEILING:    cfg_next.range_ceiling         = cfg_data;
                REG_TARGET:     cfg_next.target_speed          = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_proportional     <= 16'sd384;
            cfg_reg.gain_integral         <= 16'sd0;
            cfg_reg.gain_derivative       <= 16'sd26;
            cfg_reg.sample_period         <= 16'd256;
            cfg_reg.inverse_sample_period <= 16'd256;
            cfg_reg.output_limit          <= 15'd512;
            cfg_reg.range_ceiling         <= 16'hFFFF;
            cfg_reg.target_speed          <= 16'd179;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ src/wcpid_ctrl.sv @@
// ============================================================================
// wcpid_ctrl
// Sequencer: streams samples, then steps the shared multiplier through the PID
// ============================================================================
`default_nettype none

module wcpid_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tlast,
    output logic             s_tready,
    input  wire wcpid_pkg::sts_t sts,
    output wcpid_pkg::cmd_t  cmd
);
    import wcpid_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign take = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (take && s_tlast) state_next = ST_DERIV;
            ST_DERIV: state_next = ST_INCR;
            ST_INCR:  state_next = ST_PROP;
            ST_PROP:  state_next = ST_INTG;
            ST_INTG:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_OUT;
            ST_OUT:   if (sts.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        cmd.sample_take = 1'b0;
        cmd.op          = OP_NONE;
        cmd.finish      = 1'b0;
        cmd.load_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready        = 1'b1;
                cmd.sample_take = s_tvalid;
            end
            ST_DERIV: cmd.op = OP_DERIV;
            ST_INCR:  cmd.op = OP_INCR;
            ST_PROP:  cmd.op = OP_PROP;
            ST_INTG:  cmd.op = OP_INTG;
            ST_DIFF:  cmd.op = OP_DIFF;
            ST_SUM:   cmd.op = OP_NONE;
            ST_CLAMP: cmd.finish = 1'b1;
            ST_OUT:   cmd.load_out = sts.out_free;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ src/wcpid_dp.sv @@
// ============================================================================
// wcpid_dp
// Datapath: sector minima, shared multiplier, accumulator, clamp and output
// ============================================================================
`default_nettype none

module wcpid_dp (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire wcpid_pkg::cfg_t cfg,
    input  wire wcpid_pkg::cmd_t cmd,
    output wcpid_pkg::sts_t      sts,
    input  wire logic [15:0]     range_sample,
    input  wire logic            end_of_scan,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [31:0]          m_tdata,
    output logic                 m_tuser
);
    import wcpid_pkg::*;

    logic [9:0]         pos_reg, pos_next;
    logic [15:0]        rmin_reg, rmin_next;
    logic [15:0]        lmin_reg, lmin_next;
    logic [15:0]        sample_sat, rmin_cur, lmin_cur;
    logic               in_right, in_left;

    logic signed [16:0] er;
    logic signed [17:0] de;
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_p;
    logic signed [49:0] prod_reg;
    logic signed [49:0] prod_rnd;
    op_t                pend_reg;

    logic signed [25:0] deriv_reg;
    logic signed [24:0] incr_reg;
    logic signed [49:0] acc_reg;
    logic signed [49:0] acc_rnd;
    logic signed [41:0] drive, lim, drive_clamped;
    logic               sat;
    logic signed [32:0] int_sum;
    logic signed [31:0] int_sat;

    logic signed [31:0] integral_reg;
    logic signed [16:0] prev_err_reg;
    logic [15:0]        speed_reg;
    logic [16:0]        speed_inc;
    logic [15:0]        speed_next;

    logic [15:0]        res_steer_reg;
    logic [15:0]        res_speed_reg;
    logic               res_sat_reg;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;
    logic               out_user_reg;

    // sector tracking
    assign sample_sat = (range_sample > cfg.range_ceiling) ? cfg.range_ceiling : range_sample;
    assign rmin_cur   = (pos_reg == '0) ? cfg.range_ceiling : rmin_reg;
    assign lmin_cur   = (pos_reg == '0) ? cfg.range_ceiling : lmin_reg;
    assign in_right   = pos_reg < RIGHT_SECTOR_END;
    assign in_left    = (pos_reg >= LEFT_SECTOR_START) && ({1'b0, pos_reg} < SCAN_LENGTH);

    always_comb begin
        rmin_next = rmin_cur;
        lmin_next = lmin_cur;
        if (in_right && sample_sat < rmin_cur) rmin_next = sample_sat;
        if (in_left && sample_sat < lmin_cur)  lmin_next = sample_sat;
        if (end_of_scan) begin
            pos_next = '0;
        end else if (pos_reg < POSITION_MAX) begin
            pos_next = pos_reg + 10'd1;
        end else begin
            pos_next = pos_reg;
        end
    end

    // error terms
    assign er = $signed({1'b0, rmin_reg}) - $signed({1'b0, lmin_reg});
    assign de = $signed({er[16], er}) - $signed({prev_err_reg[16], prev_err_reg});

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_DERIV: begin
                mul_a = {{15{de[17]}}, de};
                mul_b = $signed({1'b0, cfg.inverse_sample_period});
            end
            OP_INCR: begin
                mul_a = {{16{er[16]}}, er};
                mul_b = $signed({1'b0, cfg.sample_period});
            end
            OP_PROP: begin
                mul_a = {{16{er[16]}}, er};
                mul_b = {cfg.gain_proportional[15], cfg.gain_proportional};
            end
            OP_INTG: begin
                mul_a = {integral_reg[31], integral_reg};
                mul_b = {cfg.gain_integral[15], cfg.gain_integral};
            end
            OP_DIFF: begin
                mul_a = {{7{deriv_reg[25]}}, deriv_reg};
                mul_b = {cfg.gain_derivative[15], cfg.gain_derivative};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_rnd = prod_reg + 50'sd128;

    // round, clamp, anti-windup integral
    assign acc_rnd = acc_reg + 50'sd128;
    assign drive   = acc_rnd[49:8];
    assign lim     = $signed({27'b0, cfg.output_limit});

    always_comb begin
        sat           = 1'b1;
        drive_clamped = drive;
        if (drive > lim) begin
            drive_clamped = lim;
        end else if (drive < -lim) begin
            drive_clamped = -lim;
        end else begin
            sat = 1'b0;
        end
    end

    assign int_sum = $signed({integral_reg[31], integral_reg})
                   + $signed({{8{incr_reg[24]}}, incr_reg});

    always_comb begin
        if (int_sum[32] != int_sum[31]) begin
            int_sat = int_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            int_sat = int_sum[31:0];
        end
    end

    assign speed_inc = {1'b0, speed_reg} + {1'b0, SPEED_STEP};

    always_comb begin
        speed_next = speed_reg;
        if (speed_reg < cfg.target_speed) begin
            speed_next = speed_inc[16] ? 16'hFFFF : speed_inc[15:0];
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign m_tuser      = out_user_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        case (pend_reg)
            OP_DERIV: deriv_reg <= prod_rnd[33:8];
            OP_INCR:  incr_reg  <= prod_rnd[32:8];
            OP_PROP:  acc_reg   <= prod_reg;
            OP_INTG,
            OP_DIFF:  acc_reg   <= acc_reg + prod_reg;
            default:  acc_reg   <= acc_reg;
        endcase
        if (cmd.finish) begin
            res_steer_reg <= drive_clamped[15:0];
            res_speed_reg <= speed_next;
            res_sat_reg   <= sat;
        end
        if (cmd.load_out) begin
            out_data_reg <= {res_speed_reg, res_steer_reg};
            out_user_reg <= res_sat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            rmin_reg      <= 16'hFFFF;
            lmin_reg      <= 16'hFFFF;
            pend_reg      <= OP_NONE;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            speed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.op;
            if (cmd.sample_take) begin
                pos_reg  <= pos_next;
                rmin_reg <= rmin_next;
                lmin_reg <= lmin_next;
            end
            if (cmd.finish) begin
                prev_err_reg <= er;
                speed_reg    <= speed_next;
                if (!sat) integral_reg <= int_sat;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
